// ===== sv/wpts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the waypoint time scaler.
// No dependencies; imported by wpts_div and waypoint_time_scaler_unit.
package wpts_pkg;

    localparam int NUM_POS    = 6;
    localparam int POS_W      = 32;
    localparam int TIME_W     = 48;
    localparam int COUNT_W    = 8;
    localparam int VEL_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int DIVIDEND_W = POS_W + 1 + FRAC_W;
    localparam int DIVISOR_W  = VEL_W;
    localparam int S_TDATA_W  = NUM_POS * POS_W + COUNT_W;
    localparam int M_TDATA_W  = TIME_W + NUM_POS * POS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int JNT_W      = 3;

    // 0.001 rad/s in Q16.16 and 0.01 s in Q32.16, both rounded to nearest
    localparam logic [VEL_W-1:0]  VMAX_FLOOR = 32'd66;
    localparam logic [TIME_W-1:0] DT_FLOOR   = 48'd655;

    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL_5   = 3'd6;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_JOINTS = 2'd1,
        STATUS_BAD_COUNT = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_LOAD,
        S_DIV,
        S_SUM,
        S_OUT
    } state_t;

endpackage

// ===== sv/wpts_div.sv =====
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on wpts_pkg for operand widths.
module wpts_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [wpts_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [wpts_pkg::DIVISOR_W-1:0]   divisor,
    output logic                             done,
    output logic [wpts_pkg::DIVIDEND_W-1:0]  quotient
);
    import wpts_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits  = ~diff[DIVISOR_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/waypoint_time_scaler_unit.sv =====
`timescale 1ns / 1ps
// Top level of the velocity-limited waypoint time scaler.
// Depends on wpts_pkg and wpts_div.
//
// Usage:
//   s_ channel takes one waypoint per transaction: six Q16.16 joint
//   positions and the request's waypoint count. m_ channel returns one
//   point per waypoint: the Q32.16 time stamp and the active joint
//   positions in m_tdata, the status in m_tuser and the end-of-request
//   mark in m_tlast. The cfg_ channel writes joint_count (index 0) and
//   max_vel_0..5 (indexes 1..6); write it only while the block is idle.
// Sequence: a first point or an errored waypoint goes from S_EVAL straight
//   to S_OUT. A later point runs one division per active joint on the
//   shared divider (S_LOAD then S_DIV per joint), then S_SUM and S_OUT;
//   the divider forms its 49-bit quotient one bit a cycle.
// Flow: one waypoint at a time; s_tready is high only when idle, so the
//   next waypoint can be taken the cycle after the result leaves.
// Reset: clears elapsed time, point index and stored positions, restores
//   joint_count to 6 and every max_vel to 1.0 rad/s.
// Stall: a result holds on m_ while m_tready is low; no new waypoint is
//   taken until it leaves.
module waypoint_time_scaler_unit #(
    parameter int JOINTS          = 6,
    parameter int MAX_REQ_POINTS  = 64,
    parameter int MAX_PLAN_POINTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input waypoints
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_0 .. pos_5, waypoint_count
    input  logic [wpts_pkg::S_TDATA_W-1:0]   s_tdata,
    // timed points
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // point_time, out_pos_0 .. out_pos_5
    output logic [wpts_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wpts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wpts_pkg::VEL_W-1:0]       cfg_data
);
    import wpts_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [JNT_W-1:0] joint_count_reg;
    logic [VEL_W-1:0] max_vel_reg [NUM_POS];

    // request state
    logic [POS_W-1:0]   prev_pos_reg [NUM_POS];
    logic [POS_W-1:0]   prev_pos_next [NUM_POS];
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0] index_reg, index_next;

    // latched waypoint and per-item work
    logic [POS_W-1:0]   in_pos_reg [NUM_POS];
    logic [COUNT_W-1:0] count_reg;
    logic [JNT_W-1:0]   jnt_reg, jnt_next;
    logic [TIME_W-1:0]  dt_reg, dt_next;

    // result register
    logic [TIME_W-1:0]  out_time_reg, out_time_next;
    logic [POS_W-1:0]   out_pos_reg [NUM_POS];
    logic [POS_W-1:0]   out_pos_next [NUM_POS];
    status_t            out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               s_hs, m_hs;
    logic [JNT_W-1:0]   dof;
    status_t            status;
    logic               is_last;
    logic               div_start, div_done;
    logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [POS_W:0]        pos_diff;
    logic [POS_W:0]        dq;
    logic [VEL_W-1:0]      vsel;
    logic [TIME_W-1:0]     jt, dt_floored;
    logic [TIME_W:0]       time_sum;
    logic [TIME_W-1:0]     time_sat;

    assign s_hs      = s_tvalid & s_tready;
    assign m_hs      = m_tvalid & m_tready;
    assign cfg_ready = 1'b1;

    // active joints, clamped to the build-time joint count
    assign dof = (joint_count_reg > JNT_W'(JOINTS)) ? JNT_W'(JOINTS) : joint_count_reg;

    // error precedence: no joints, then bad count, then plan overflow
    always_comb begin
        priority if (dof == '0)
            status = STATUS_NO_JOINTS;
        else if (count_reg < COUNT_W'(2) || count_reg > COUNT_W'(MAX_REQ_POINTS))
            status = STATUS_BAD_COUNT;
        else if (count_reg > COUNT_W'(MAX_PLAN_POINTS))
            status = STATUS_OVERFLOW;
        else
            status = STATUS_OK;
    end

    assign is_last = ({1'b0, index_reg} + 1'b1) >= {1'b0, count_reg};

    // operands for the selected joint: |dq| << 16 over the floored speed
    assign pos_diff = {in_pos_reg[jnt_reg][POS_W-1], in_pos_reg[jnt_reg]}
                    - {prev_pos_reg[jnt_reg][POS_W-1], prev_pos_reg[jnt_reg]};
    assign dq       = pos_diff[POS_W] ? (~pos_diff + 1'b1) : pos_diff;
    assign vsel     = max_vel_reg[jnt_reg];
    assign div_dividend = {dq, {FRAC_W{1'b0}}};
    assign div_divisor  = (vsel < VMAX_FLOOR) ? VMAX_FLOOR : vsel;

    // quotient stays below 2^42, so the top bit is always clear
    assign jt = div_quotient[TIME_W-1:0];

    // floor the segment time, add, saturate
    assign dt_floored = (dt_reg < DT_FLOOR) ? DT_FLOOR : dt_reg;
    assign time_sum   = {1'b0, elapsed_reg} + {1'b0, dt_floored};
    assign time_sat   = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];

    wpts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_hs) state_next = S_EVAL;
            end
            S_EVAL: begin
                if (status != STATUS_OK || index_reg == '0)
                    state_next = S_OUT;
                else
                    state_next = S_LOAD;
            end
            S_LOAD: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done)
                    state_next = (jnt_reg + 1'b1 == dof) ? S_SUM : S_LOAD;
            end
            S_SUM: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_hs) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_tready  = 1'b1;
            S_LOAD:  div_start = 1'b1;
            S_OUT:   m_tvalid  = 1'b1;
            S_EVAL, S_DIV, S_SUM: ;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        elapsed_next    = elapsed_reg;
        index_next      = index_reg;
        jnt_next        = jnt_reg;
        dt_next         = dt_reg;
        out_time_next   = out_time_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        for (int j = 0; j < NUM_POS; j++) begin
            prev_pos_next[j] = prev_pos_reg[j];
            out_pos_next[j]  = out_pos_reg[j];
        end

        unique case (state_reg)
            S_EVAL: begin
                jnt_next = '0;
                dt_next  = '0;
                if (status != STATUS_OK) begin
                    // drop the request: zero result, restart on the next item
                    out_time_next   = '0;
                    out_status_next = status;
                    out_last_next   = 1'b1;
                    elapsed_next    = '0;
                    index_next      = '0;
                    for (int j = 0; j < NUM_POS; j++)
                        out_pos_next[j] = '0;
                end else if (index_reg == '0) begin
                    // first point of a request sits at time zero
                    out_time_next   = '0;
                    out_status_next = STATUS_OK;
                    out_last_next   = is_last;
                    elapsed_next    = '0;
                    index_next      = is_last ? '0 : index_reg + 1'b1;
                    for (int j = 0; j < NUM_POS; j++) begin
                        prev_pos_next[j] = in_pos_reg[j];
                        out_pos_next[j]  = (JNT_W'(j) < dof) ? in_pos_reg[j] : '0;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (jt > dt_reg) dt_next = jt;
                    jnt_next = jnt_reg + 1'b1;
                end
            end
            S_SUM: begin
                out_time_next   = time_sat;
                out_status_next = STATUS_OK;
                out_last_next   = is_last;
                elapsed_next    = is_last ? '0 : time_sat;
                index_next      = is_last ? '0 : index_reg + 1'b1;
                for (int j = 0; j < NUM_POS; j++) begin
                    prev_pos_next[j] = in_pos_reg[j];
                    out_pos_next[j]  = (JNT_W'(j) < dof) ? in_pos_reg[j] : '0;
                end
            end
            S_IDLE, S_LOAD, S_OUT: ;
            default: ;
        endcase
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            joint_count_reg <= JNT_W'(NUM_POS);
            for (int j = 0; j < NUM_POS; j++) begin
                max_vel_reg[j]  <= VEL_W'(32'h0001_0000);
                prev_pos_reg[j] <= '0;
            end
            elapsed_reg     <= '0;
            index_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            index_reg   <= index_next;
            for (int j = 0; j < NUM_POS; j++)
                prev_pos_reg[j] <= prev_pos_next[j];
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_JOINT_COUNT)
                    joint_count_reg <= cfg_data[JNT_W-1:0];
                else if (cfg_index >= CFG_MAX_VEL_0 && cfg_index <= CFG_MAX_VEL_5)
                    max_vel_reg[cfg_index - CFG_MAX_VEL_0] <= cfg_data;
            end
        end
    end

    // payload: latch the waypoint on acceptance, advance work registers
    always_ff @(posedge aclk) begin
        if (s_hs) begin
            for (int j = 0; j < NUM_POS; j++)
                in_pos_reg[j] <= s_tdata[j*POS_W +: POS_W];
            count_reg <= s_tdata[NUM_POS*POS_W +: COUNT_W];
        end
        jnt_reg        <= jnt_next;
        dt_reg         <= dt_next;
        out_time_reg   <= out_time_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        for (int j = 0; j < NUM_POS; j++)
            out_pos_reg[j] <= out_pos_next[j];
    end

    always_comb begin
        m_tdata[TIME_W-1:0] = out_time_reg;
        for (int j = 0; j < NUM_POS; j++)
            m_tdata[TIME_W + j*POS_W +: POS_W] = out_pos_reg[j];
    end
    assign m_tuser = out_status_reg;
    assign m_tlast = out_last_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for waypoint_time_scaler_unit: stream driver, receiver,
// checker and a transaction-level model of the segment timing.
// Depends on wpts_pkg and the unit.
module tb;
    import wpts_pkg::*;

    localparam int JOINTS          = 6;
    localparam int MAX_REQ_POINTS  = 64;
    localparam int MAX_PLAN_POINTS = 64;
    localparam int STALL_LIMIT     = 4000;   // cycles with no transaction anywhere
    localparam int HOLD_CYCLES     = 700;    // long receiver back-off
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_CHUNKS    = 4;
    localparam int CHUNK_ITEMS     = 25;
    localparam int HOLD_PHASE      = 2;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    // index past the last speed register; the unit ignores it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_MAX_VEL_5 + 1'b1;

    // s_tdata layout: pos_0 in the low bits, waypoint_count on top
    typedef struct packed {
        logic [COUNT_W-1:0]            count;
        logic [NUM_POS-1:0][POS_W-1:0] pos;
    } waypoint_t;

    // m_tdata layout: point_time in the low bits, out_pos_0 .. out_pos_5 above
    typedef struct packed {
        logic [NUM_POS-1:0][POS_W-1:0] pos;
        logic [TIME_W-1:0]             stamp;
    } point_data_t;

    typedef struct {
        point_data_t data;
        status_t     status;
        logic        is_last;
    } point_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [VEL_W-1:0]       cfg_data  = '0;

    // pending stimulus and expected results
    waypoint_t pend_q[$];
    point_t    exp_q[$];

    int sent_cnt = 0;
    int recv_cnt = 0;
    int err_cnt  = 0;
    int drv_wait = 0;
    int rcv_wait = 0;
    int hold_cnt = 0;
    int idle_cnt = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    // model state and configuration mirror
    logic [JNT_W-1:0]   m_joint_count;
    logic [VEL_W-1:0]   m_max_vel [NUM_POS];
    logic [POS_W-1:0]   m_prev [NUM_POS];
    logic [TIME_W-1:0]  m_elapsed;
    int                 m_index;

    // generator state
    logic [POS_W-1:0]   gen_pos [NUM_POS];
    logic [COUNT_W-1:0] req_count;
    int                 req_left;

    waypoint_time_scaler_unit #(
        .JOINTS          (JOINTS),
        .MAX_REQ_POINTS  (MAX_REQ_POINTS),
        .MAX_PLAN_POINTS (MAX_PLAN_POINTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_cnt = err_cnt + 1;
    endtask

    // one waypoint through the model; advances the model state
    function automatic void model_step(input waypoint_t w, output point_t p);
        int          dof;
        status_t     st;
        longint      diff;
        logic [63:0] dq, v, jt, dt, t;
        dof = int'(m_joint_count);
        if (dof > JOINTS) dof = JOINTS;
        p.data    = '0;
        p.status  = STATUS_OK;
        p.is_last = 1'b0;
        if (dof == 0)
            st = STATUS_NO_JOINTS;
        else if (w.count < 2 || w.count > MAX_REQ_POINTS)
            st = STATUS_BAD_COUNT;
        else if (w.count > MAX_PLAN_POINTS)
            st = STATUS_OVERFLOW;
        else
            st = STATUS_OK;

        if (st != STATUS_OK) begin
            p.status  = st;
            p.is_last = 1'b1;
            m_elapsed = '0;
            m_index   = 0;
        end else begin
            if (m_index != 0) begin
                dt = '0;
                for (int j = 0; j < dof; j++) begin
                    diff = longint'($signed(w.pos[j])) - longint'($signed(m_prev[j]));
                    dq   = (diff < 0) ? 64'(-diff) : 64'(diff);
                    v    = 64'(m_max_vel[j]);
                    if (v < 64'(VMAX_FLOOR)) v = 64'(VMAX_FLOOR);
                    jt = (dq << 16) / v;
                    if (jt > dt) dt = jt;
                end
                if (dt < 64'(DT_FLOOR)) dt = 64'(DT_FLOOR);
                t = 64'(m_elapsed) + dt;
                m_elapsed = (t > 64'(TIME_MAX)) ? TIME_MAX : t[TIME_W-1:0];
            end else begin
                m_elapsed = '0;
            end
            p.data.stamp = m_elapsed;
            for (int j = 0; j < NUM_POS; j++) begin
                p.data.pos[j] = (j < dof) ? w.pos[j] : '0;
                m_prev[j]     = w.pos[j];
            end
            if (m_index + 1 >= int'(w.count)) begin
                p.is_last = 1'b1;
                m_elapsed = '0;
                m_index   = 0;
            end else begin
                m_index = (m_index + 1) & 255;
            end
        end
    endfunction

    // one configuration write; updates the mirror at the accepting edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VEL_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_JOINT_COUNT)
            m_joint_count = val[JNT_W-1:0];
        else if (idx >= CFG_MAX_VEL_0 && idx <= CFG_MAX_VEL_5)
            m_max_vel[idx - CFG_MAX_VEL_0] = val;
    endtask

    task automatic randomize_config();
        int               sel;
        logic [VEL_W-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            cfg_write(CFG_JOINT_COUNT, '0);
        else if (sel == 1)
            cfg_write(CFG_JOINT_COUNT, $urandom);
        else
            cfg_write(CFG_JOINT_COUNT, VEL_W'($urandom_range(1, 7)));
        for (int j = 0; j < NUM_POS; j++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                v = '0;
            else if (sel == 1)
                v = VEL_W'($urandom_range(1, 66));
            else if (sel == 2)
                v = $urandom;
            else if (sel == 3)
                v = VEL_W'($urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
            else
                v = VEL_W'($urandom_range(32'h0000_1000, 32'h0004_0000));
            cfg_write(CFG_MAX_VEL_0 + CFG_IDX_W'(j), v);
        end
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_SPARE, $urandom);
    endtask

    task automatic make_item(output waypoint_t w);
        int sel;
        int delta;
        if (req_left == 0) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                req_count = COUNT_W'($urandom_range(0, 1));
            else if (sel == 1)
                req_count = COUNT_W'($urandom_range(MAX_REQ_POINTS + 1, 255));
            else if (sel == 2)
                req_count = COUNT_W'(MAX_REQ_POINTS);
            else
                req_count = COUNT_W'($urandom_range(2, 9));
            if (req_count < 2 || req_count > MAX_REQ_POINTS)
                req_left = 1;
            else
                req_left = int'(req_count);
        end
        req_left = req_left - 1;
        w.count  = req_count;
        // now and then a count that disagrees with the rest of the request
        if ($urandom_range(0, 29) == 0)
            w.count = COUNT_W'($urandom_range(0, 255));
        for (int j = 0; j < NUM_POS; j++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                gen_pos[j] = $urandom;
            end else if (sel == 1) begin
                gen_pos[j] = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (sel >= 3) begin
                delta = int'($urandom_range(0, 32'h0004_0000)) - int'(32'h0002_0000);
                gen_pos[j] = gen_pos[j] + POS_W'(delta);
            end
            w.pos[j] = gen_pos[j];
        end
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pend_q.size() != 0 || s_tvalid || recv_cnt != sent_cnt);
    endtask

    // driver: predict on acceptance, then offer the next pending waypoint
    always @(posedge aclk) begin : driver
        point_t exp_p;
        logic   valid_n;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            drv_wait  = 0;
        end else begin
            valid_n = s_tvalid;
            if (s_tvalid && s_tready) begin
                model_step(waypoint_t'(s_tdata), exp_p);
                exp_q.push_back(exp_p);
                sent_cnt = sent_cnt + 1;
                drv_wait = $urandom_range(0, 8);
                valid_n  = 1'b0;
            end
            if (!valid_n) begin
                if (drv_wait > 0) begin
                    drv_wait = drv_wait - 1;
                end else if (pend_q.size() > 0) begin
                    s_tdata <= pend_q.pop_front();
                    valid_n  = 1'b1;
                end
            end
            s_tvalid <= valid_n;
        end
    end

    // receiver: random back-off after each result, one long hold on request
    always @(posedge aclk) begin : receiver
        logic ready_n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rcv_wait  = 0;
            hold_cnt  = 0;
            hold_done = 1'b0;
        end else begin
            ready_n = m_tready;
            if (m_tvalid && m_tready) begin
                rcv_wait = $urandom_range(0, 8);
                ready_n  = 1'b0;
            end
            if (hold_req && !hold_done) begin
                hold_cnt  = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_cnt > 0) begin
                hold_cnt = hold_cnt - 1;
                ready_n  = 1'b0;
            end else if (!ready_n) begin
                if (rcv_wait > 0)
                    rcv_wait = rcv_wait - 1;
                else
                    ready_n = 1'b1;
            end
            m_tready <= ready_n;
        end
    end

    // monitor: compare every result against the oldest prediction
    always @(posedge aclk) begin : monitor
        point_t exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_q.size() == 0) begin
                report_mismatch("result with no waypoint outstanding");
            end else begin
                exp_p = exp_q.pop_front();
                if (m_tdata !== exp_p.data || m_tuser !== exp_p.status
                        || m_tlast !== exp_p.is_last)
                    report_mismatch($sformatf(
                        "result %0d: data %h exp %h, status %0d exp %0d, last %b exp %b",
                        recv_cnt, m_tdata, exp_p.data, m_tuser, exp_p.status,
                        m_tlast, exp_p.is_last));
            end
            recv_cnt = recv_cnt + 1;
        end
    end

    // watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin : watchdog
        if (!aresetn) begin
            idle_cnt = 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt = idle_cnt + 1;
            if (idle_cnt >= STALL_LIMIT) begin
                report_mismatch("no transaction within the stall limit");
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        waypoint_t w;
        m_joint_count = JNT_W'(NUM_POS);
        for (int j = 0; j < NUM_POS; j++) begin
            m_max_vel[j] = VEL_W'(32'h0001_0000);
            m_prev[j]    = '0;
            gen_pos[j]   = '0;
        end
        m_elapsed = '0;
        m_index   = 0;
        req_count = '0;
        req_left  = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int ck = 0; ck < PHASE_CHUNKS; ck++) begin
                // the first chunk runs on the reset configuration
                if (ph != 0 || ck != 0)
                    randomize_config();
                @(negedge aclk);
                if (ph == HOLD_PHASE && ck == 1)
                    hold_req = 1'b1;
                for (int k = 0; k < CHUNK_ITEMS; k++) begin
                    make_item(w);
                    pend_q.push_back(w);
                end
                wait_drained();
            end
        end

        if (err_cnt == 0 && exp_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== waypoint_time_scaler_unit.f =====
sv/wpts_pkg.sv
sv/wpts_div.sv
sv/waypoint_time_scaler_unit.sv
sim/tb.sv
